>>> hw/rtl/density_heatmap_colorizer_defines.svh
// Assertion helpers used by the colorizer RTL.
`ifndef DENSITY_HEATMAP_COLORIZER_DEFINES_SVH
`define DENSITY_HEATMAP_COLORIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DHC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dhc_pkg.sv
package dhc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 10;

    // Level scale: the level runs 0..250 in LEVEL_BITS integer bits.
    localparam int LEVEL_TOP  = 250;
    localparam int LEVEL_BITS = 8;

    // Hue ramp breakpoints and slope (4.25 = 17/4).
    localparam int BRK_1    = 60;
    localparam int BRK_2    = 120;
    localparam int BRK_3    = 180;
    localparam int BRK_4    = 240;
    localparam int SLOPE_X4 = 17;

    localparam logic [7:0] BYTE_FULL = 8'd255;
    localparam logic [7:0] BYTE_OFF  = 8'd0;

    // Config port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam int MAXP_W = 16;
    localparam logic [APB_AW-3:0] REG_MAX_PARTICLE = '0;
    localparam logic [MAXP_W-1:0] MAXP_RESET       = 16'd1;

    typedef struct packed {
        logic [15:0] particle_count;
        logic        ground_contact;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
    } pixel_out_t;

    // Sideband that rides along the divider stages.
    typedef struct packed {
        logic ground;
        logic sat;
    } div_tag_t;

    localparam pixel_out_t GROUND_COLOR = '{byte_zero: 8'd19, byte_one: 8'd69,
                                           byte_two: 8'd139};

endpackage

>>> hw/rtl/dhc_div_pipe.sv
module dhc_div_pipe #(
    parameter int COUNT_BITS = dhc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = dhc_pkg::FRAC_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       adv,
    input  logic                                       in_valid,
    input  dhc_pkg::div_tag_t                          in_tag,
    input  logic [COUNT_BITS-1:0]                      in_rem,
    input  logic [dhc_pkg::LEVEL_BITS+FRAC_BITS-1:0]   in_low,
    input  logic [COUNT_BITS-1:0]                      den,
    output logic                                       out_valid,
    output dhc_pkg::div_tag_t                          out_tag,
    output logic [dhc_pkg::LEVEL_BITS+FRAC_BITS-1:0]   out_quo
);
    import dhc_pkg::*;

    localparam int QW = LEVEL_BITS + FRAC_BITS;
    localparam int CW = COUNT_BITS;

    // One restoring step per stage: remaining dividend bits shift out of
    // the top of lq while quotient bits shift in at the bottom.
    logic            v_reg   [QW];
    div_tag_t        tag_reg [QW];
    logic [CW-1:0]   rem_reg [QW];
    logic [QW-1:0]   lq_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          v_prev;
        div_tag_t      tag_prev;
        logic [CW-1:0] rem_prev;
        logic [QW-1:0] lq_prev;
        logic [CW:0]   trial;
        logic [CW:0]   diff;
        logic          ge;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] lq_next;

        if (i == 0) begin : g_first
            assign v_prev   = in_valid;
            assign tag_prev = in_tag;
            assign rem_prev = in_rem;
            assign lq_prev  = in_low;
        end else begin : g_rest
            assign v_prev   = v_reg[i-1];
            assign tag_prev = tag_reg[i-1];
            assign rem_prev = rem_reg[i-1];
            assign lq_prev  = lq_reg[i-1];
        end

        assign trial    = {rem_prev, lq_prev[QW-1]};
        assign diff     = trial - {1'b0, den};
        assign ge       = (trial >= {1'b0, den});
        assign rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
        assign lq_next  = {lq_prev[QW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv) begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                tag_reg[i] <= tag_prev;
                rem_reg[i] <= rem_next;
                lq_reg[i]  <= lq_next;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];
    assign out_quo   = lq_reg[QW-1];

endmodule

>>> hw/rtl/density_heatmap_colorizer.sv
// Density heat-map colorizer: turns a per-site particle count into three
// color bytes through a rainbow hue ramp; ground sites come out brown.
//
// Channels: s_valid/s_ready/s_data carry one pixel request (particle count
// plus ground flag), m_valid/m_ready/m_data carry one color triple back.
// An APB-style port writes max_particle at byte address 0; pready is tied
// high. Write it only while no request is in flight.
//
// Stages from accept to m_valid: one entry stage that scales the count by
// 250, one divider stage per quotient bit, one stage that picks the ramp
// segment, one output register that applies the slope.
// Throughput: one pixel per clock while the receiver takes results; the
// restoring divider is fully pipelined, one quotient bit per stage.
//
// Reset (aresetn low, synchronous) empties every stage and sets
// max_particle to 1. When the receiver stalls, every stage behind the output
// holds; the entry stage still takes one more request if it was empty.
`include "density_heatmap_colorizer_defines.svh"

module density_heatmap_colorizer #(
    parameter int COUNT_BITS = dhc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = dhc_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Pixel requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dhc_pkg::pixel_in_t            s_data,
    // Color results
    output logic                          m_valid,
    input  logic                          m_ready,
    output dhc_pkg::pixel_out_t           m_data,
    // Config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhc_pkg::APB_AW-1:0]    paddr,
    input  logic [dhc_pkg::APB_DW-1:0]    pwdata,
    output logic [dhc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import dhc_pkg::*;

    localparam int CW = COUNT_BITS;
    localparam int PW = COUNT_BITS + LEVEL_BITS;   // count * 250
    localparam int QW = LEVEL_BITS + FRAC_BITS;    // fixed-point level
    localparam int DW = $clog2(BRK_1 + 1) + FRAC_BITS; // ramp distance
    localparam int RW = DW + 5;                    // distance * 17

    localparam logic [QW-1:0] TOP_FX  = QW'(LEVEL_TOP) << FRAC_BITS;
    localparam logic [QW-1:0] BRK1_FX = QW'(BRK_1) << FRAC_BITS;
    localparam logic [QW-1:0] BRK2_FX = QW'(BRK_2) << FRAC_BITS;
    localparam logic [QW-1:0] BRK3_FX = QW'(BRK_3) << FRAC_BITS;
    localparam logic [QW-1:0] BRK4_FX = QW'(BRK_4) << FRAC_BITS;

    // Hue ramp segments, in order of rising level.
    typedef enum logic [2:0] {
        SEG_GREEN_UP = 3'd0,
        SEG_BLUE_DN  = 3'd1,
        SEG_RED_UP   = 3'd2,
        SEG_GREEN_DN = 3'd3,
        SEG_BLUE_UP  = 3'd4
    } seg_t;

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [MAXP_W-1:0]   max_particle_reg;
    logic [APB_AW-3:0]   reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_particle_reg <= MAXP_RESET;
        end else if (cfg_wr && (reg_idx == REG_MAX_PARTICLE)) begin
            max_particle_reg <= pwdata[MAXP_W-1:0];
        end
    end

    // Decode reads; unknown addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            REG_MAX_PARTICLE: prdata = APB_DW'(max_particle_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: one advance for the whole pipe, stalled only by a
    // result that waits at the output. The entry stage also fills a bubble.
    // ------------------------------------------------------------------
    logic adv;
    logic out_v_reg;
    logic v1_reg;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = adv || !v1_reg;

    // ------------------------------------------------------------------
    // Entry stage: scale the count by 250 and flag saturation
    // ------------------------------------------------------------------
    logic [CW-1:0]   count;
    logic [CW-1:0]   den;
    logic [PW-1:0]   prod;
    div_tag_t        tag_next;
    div_tag_t        tag1_reg;
    logic [CW-1:0]   rem1_reg;
    logic [QW-1:0]   lq1_reg;

    assign count = CW'(s_data.particle_count);
    assign den   = CW'(max_particle_reg);
    assign prod  = PW'(count) * PW'(LEVEL_TOP);

    // Level hits the top exactly when count >= max_particle; a zero
    // divisor saturates as well.
    assign tag_next.ground = s_data.ground_contact;
    assign tag_next.sat    = (den == '0) || (count >= den);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    // Seed the divider with the top bits of the dividend; they stay below
    // the divisor whenever the level does not saturate.
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            tag1_reg <= tag_next;
            rem1_reg <= prod[PW-1:LEVEL_BITS];
            lq1_reg  <= {prod[LEVEL_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Pipelined divider: level = count * 250 * 2^FRAC_BITS / max_particle
    // ------------------------------------------------------------------
    logic            div_valid;
    div_tag_t        div_tag;
    logic [QW-1:0]   div_quo;

    dhc_div_pipe #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v1_reg),
        .in_tag    (tag1_reg),
        .in_rem    (rem1_reg),
        .in_low    (lq1_reg),
        .den       (den),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Segment stage: clamp the level, pick the ramp segment and take the
    // distance from its anchor along the slope.
    // ------------------------------------------------------------------
    logic [QW-1:0]   level;
    seg_t            seg_next;
    logic [QW-1:0]   dist_next;
    logic            va_reg;
    logic            ga_reg;
    seg_t            sega_reg;
    logic [DW-1:0]   dfa_reg;

    assign level = div_tag.sat ? TOP_FX : div_quo;

    always_comb begin
        if (level < BRK1_FX) begin
            seg_next  = SEG_GREEN_UP;
            dist_next = level;
        end else if (level < BRK2_FX) begin
            seg_next  = SEG_BLUE_DN;
            dist_next = BRK2_FX - level;
        end else if (level < BRK3_FX) begin
            seg_next  = SEG_RED_UP;
            dist_next = level - BRK2_FX;
        end else if (level < BRK4_FX) begin
            seg_next  = SEG_GREEN_DN;
            dist_next = BRK4_FX - level;
        end else begin
            seg_next  = SEG_BLUE_UP;
            dist_next = level - BRK4_FX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= div_valid;
        end
    end

    // Distance never exceeds one segment width, so DW bits hold it.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ga_reg   <= div_tag.ground;
            sega_reg <= seg_next;
            dfa_reg  <= dist_next[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: ramp = floor(17 * dist / 2^(FRAC_BITS+2)), then place
    // the three bytes for the segment; ground overrides with brown.
    // ------------------------------------------------------------------
    logic [RW-1:0]   slope_prod;
    logic [RW-1:0]   slope_shift;
    logic [7:0]      ramp;
    pixel_out_t      pix_next;
    pixel_out_t      out_data_reg;
    logic            out_ground_reg;

    assign slope_prod  = RW'(dfa_reg) * RW'(SLOPE_X4);
    assign slope_shift = slope_prod >> (FRAC_BITS + 2);
    assign ramp        = slope_shift[7:0];

    always_comb begin
        case (sega_reg)
            SEG_GREEN_UP: pix_next = '{byte_zero: BYTE_FULL, byte_one: ramp,
                                       byte_two: BYTE_OFF};
            SEG_BLUE_DN:  pix_next = '{byte_zero: ramp, byte_one: BYTE_FULL,
                                       byte_two: BYTE_OFF};
            SEG_RED_UP:   pix_next = '{byte_zero: BYTE_OFF, byte_one: BYTE_FULL,
                                       byte_two: ramp};
            SEG_GREEN_DN: pix_next = '{byte_zero: BYTE_OFF, byte_one: ramp,
                                       byte_two: BYTE_FULL};
            SEG_BLUE_UP:  pix_next = '{byte_zero: ramp, byte_one: BYTE_OFF,
                                       byte_two: BYTE_FULL};
            default:      pix_next = '{byte_zero: BYTE_OFF, byte_one: BYTE_OFF,
                                       byte_two: BYTE_OFF};
        endcase
        if (ga_reg) begin
            pix_next = GROUND_COLOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg   <= pix_next;
            out_ground_reg <= ga_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `DHC_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, v1_reg,
        "accepted request did not land in the entry stage")
    `DHC_ASSERT_NOW(a_level_bound, aclk, aresetn, div_valid && !div_tag.sat, div_quo < TOP_FX,
        "unsaturated divider result reached the top of the scale")
    `DHC_ASSERT_NOW(a_hue_full, aclk, aresetn, m_valid && !out_ground_reg,
        (m_data.byte_zero == BYTE_FULL) || (m_data.byte_one == BYTE_FULL) || (m_data.byte_two == BYTE_FULL),
        "hue result has no saturated channel")
    `DHC_ASSERT_NEXT(a_ground_brown, aclk, aresetn, adv && va_reg && ga_reg,
        m_valid && (m_data == GROUND_COLOR),
        "ground pixel did not come out brown")

endmodule
